/* sv/mhpq_pkg.sv */
// ----------------------------------------------------------------------------
// mhpq_pkg
// shared types and constants for the min-heap priority queue
// ----------------------------------------------------------------------------
`default_nettype none
package mhpq_pkg;
    localparam int CAPACITY = 1024;
    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int EW = 32 + 10 + 32;

    localparam logic [1:0] OP_INSERT   = 2'd0;
    localparam logic [1:0] OP_EXTRACT  = 2'd1;
    localparam logic [1:0] OP_PEEK     = 2'd2;
    localparam logic [1:0] OP_DECREASE = 2'd3;

    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_EMPTY  = 2'd1;
    localparam logic [1:0] ST_FULL   = 2'd2;
    localparam logic [1:0] ST_NO_DEC = 2'd3;

    typedef struct packed {
        logic [1:0]         opcode;
        logic signed [31:0] key_in;
        logic [9:0]         tag_in;
        logic signed [31:0] item_id_in;
        logic signed [31:0] parent_in;
    } cmd_t;

    typedef struct packed {
        logic [1:0]         status;
        logic signed [31:0] out_key;
        logic [9:0]         out_tag;
        logic signed [31:0] out_item_id;
        logic signed [31:0] out_parent;
        logic [10:0]        occupancy;
    } rsp_t;

    typedef struct packed {
        logic signed [31:0] key;
        logic [9:0]         tag;
        logic signed [31:0] item_id;
    } entry_t;

    typedef struct packed {
        logic          we;
        logic [AW-1:0] waddr;
        entry_t        wdata;
        logic [AW-1:0] raddr_a;
        logic [AW-1:0] raddr_b;
    } mem_req_t;
endpackage
`default_nettype wire

/* sv/mhpq_ram.sv */
// ----------------------------------------------------------------------------
// mhpq_ram
// generic ram, one write port and one registered read port
// ----------------------------------------------------------------------------
`default_nettype none
module mhpq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]              rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule
`default_nettype wire

/* sv/mhpq_store.sv */
// ----------------------------------------------------------------------------
// mhpq_store
// entry store: two read ports built from two ram copies sharing writes
// ----------------------------------------------------------------------------
`default_nettype none
module mhpq_store (
    input  wire logic              clk,
    input  wire mhpq_pkg::mem_req_t req,
    output mhpq_pkg::entry_t       rdata_a,
    output mhpq_pkg::entry_t       rdata_b
);
    import mhpq_pkg::*;

    logic [EW-1:0] ra;
    logic [EW-1:0] rb;

    mhpq_ram #(.WIDTH(EW), .DEPTH(CAPACITY)) u_ram_a (
        .clk(clk), .we(req.we), .waddr(req.waddr), .wdata(req.wdata),
        .raddr(req.raddr_a), .rdata(ra)
    );
    mhpq_ram #(.WIDTH(EW), .DEPTH(CAPACITY)) u_ram_b (
        .clk(clk), .we(req.we), .waddr(req.waddr), .wdata(req.wdata),
        .raddr(req.raddr_b), .rdata(rb)
    );

    assign rdata_a = entry_t'(ra);
    assign rdata_b = entry_t'(rb);
endmodule
`default_nettype wire

/* sv/mhpq_ctrl.sv */
// ----------------------------------------------------------------------------
// mhpq_ctrl
// heap sequencer: tag search, sift up and sift down over the entry store
// ----------------------------------------------------------------------------
`default_nettype none
module mhpq_ctrl (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              start,
    input  wire mhpq_pkg::cmd_t    cmd,
    output logic                   busy,
    output logic                   done,
    output mhpq_pkg::rsp_t         rsp,
    output mhpq_pkg::mem_req_t     mreq,
    input  wire mhpq_pkg::entry_t  rdata_a,
    input  wire mhpq_pkg::entry_t  rdata_b
);
    import mhpq_pkg::*;

    localparam logic [3:0] S_IDLE    = 4'd0;
    localparam logic [3:0] S_ROOT    = 4'd1;
    localparam logic [3:0] S_MOVE    = 4'd2;
    localparam logic [3:0] S_UP_RD   = 4'd3;
    localparam logic [3:0] S_UP_CMP  = 4'd4;
    localparam logic [3:0] S_DN_RD   = 4'd5;
    localparam logic [3:0] S_DN_CMP  = 4'd6;
    localparam logic [3:0] S_SRCH    = 4'd7;
    localparam logic [3:0] S_SRCH_CK = 4'd8;
    localparam logic [3:0] S_DONE    = 4'd9;

    logic [3:0]    state_reg, state_next;
    logic [CW-1:0] count_reg, count_next;
    logic [AW-1:0] pos_reg, pos_next;
    logic [CW-1:0] idx_reg, idx_next;
    entry_t        cur_reg, cur_next;
    cmd_t          cmd_reg, cmd_next;
    rsp_t          rsp_reg, rsp_next;
    logic          done_reg, done_next;

    logic [AW-1:0] up_addr;
    logic [CW:0]   left_w;
    logic [CW:0]   right_w;
    logic [CW-1:0] last_w;
    logic          pick_right;
    entry_t        pick_e;

    assign up_addr = AW'((pos_reg - AW'(1)) >> 1);
    assign left_w  = (CW + 1)'({pos_reg, 1'b1});
    assign right_w = left_w + (CW + 1)'(1);
    assign last_w  = count_reg - CW'(1);
    assign pick_right = (left_w != (CW + 1)'(last_w)) && (rdata_a.key > rdata_b.key);
    assign pick_e  = pick_right ? rdata_b : rdata_a;

    always_comb
    begin
        state_next = state_reg;
        count_next = count_reg;
        pos_next   = pos_reg;
        idx_next   = idx_reg;
        cur_next   = cur_reg;
        cmd_next   = cmd_reg;
        rsp_next   = rsp_reg;
        done_next  = 1'b0;
        mreq       = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd_next = cmd;
                    rsp_next = '0;
                    cur_next.key     = cmd.key_in;
                    cur_next.tag     = cmd.tag_in;
                    cur_next.item_id = cmd.item_id_in;
                    mreq.raddr_a = '0;
                    mreq.raddr_b = AW'(count_reg - CW'(1));
                    case (cmd.opcode)
                        OP_INSERT:
                        begin
                            if (count_reg == CW'(CAPACITY))
                            begin
                                rsp_next.status = ST_FULL;
                                state_next = S_DONE;
                            end
                            else
                            begin
                                pos_next   = AW'(count_reg);
                                count_next = count_reg + CW'(1);
                                state_next = S_UP_RD;
                            end
                        end
                        OP_EXTRACT, OP_PEEK:
                        begin
                            if (count_reg == '0)
                            begin
                                rsp_next.status = ST_EMPTY;
                                state_next = S_DONE;
                            end
                            else
                            begin
                                state_next = S_ROOT;
                            end
                        end
                        default:
                        begin
                            rsp_next.status = ST_NO_DEC;
                            idx_next = '0;
                            state_next = S_SRCH;
                        end
                    endcase
                end
            end
            S_ROOT:
            begin
                rsp_next.out_key     = rdata_a.key;
                rsp_next.out_tag     = rdata_a.tag;
                rsp_next.out_item_id = rdata_a.item_id;
                if (cmd_reg.opcode == OP_PEEK)
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    count_next = last_w;
                    cur_next   = rdata_b;
                    pos_next   = '0;
                    state_next = S_MOVE;
                end
            end
            S_MOVE:
            begin
                // write the moved entry to the root, then sift down
                mreq.we    = 1'b1;
                mreq.waddr = '0;
                mreq.wdata = cur_reg;
                state_next = S_DN_RD;
            end
            S_DN_RD:
            begin
                if (count_reg == '0 || left_w > (CW + 1)'(last_w))
                begin
                    // no children left: the moved entry settles here
                    mreq.we    = 1'b1;
                    mreq.waddr = pos_reg;
                    mreq.wdata = cur_reg;
                    state_next = S_DONE;
                end
                else
                begin
                    mreq.raddr_a = AW'(left_w);
                    mreq.raddr_b = AW'(right_w);
                    state_next = S_DN_CMP;
                end
            end
            S_DN_CMP:
            begin
                if (cur_reg.key > pick_e.key)
                begin
                    mreq.we    = 1'b1;
                    mreq.waddr = pos_reg;
                    mreq.wdata = pick_e;
                    pos_next   = pick_right ? AW'(right_w) : AW'(left_w);
                    state_next = S_DN_RD;
                end
                else
                begin
                    mreq.we    = 1'b1;
                    mreq.waddr = pos_reg;
                    mreq.wdata = cur_reg;
                    state_next = S_DONE;
                end
            end
            S_UP_RD:
            begin
                if (pos_reg == '0)
                begin
                    mreq.we    = 1'b1;
                    mreq.waddr = pos_reg;
                    mreq.wdata = cur_reg;
                    state_next = S_DONE;
                end
                else
                begin
                    mreq.raddr_a = up_addr;
                    state_next = S_UP_CMP;
                end
            end
            S_UP_CMP:
            begin
                mreq.we    = 1'b1;
                mreq.waddr = pos_reg;
                if (rdata_a.key > cur_reg.key)
                begin
                    mreq.wdata = rdata_a;
                    pos_next   = up_addr;
                    state_next = S_UP_RD;
                end
                else
                begin
                    mreq.wdata = cur_reg;
                    state_next = S_DONE;
                end
            end
            S_SRCH:
            begin
                if (idx_reg >= count_reg)
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    mreq.raddr_a = AW'(idx_reg);
                    state_next = S_SRCH_CK;
                end
            end
            S_SRCH_CK:
            begin
                if (rdata_a.tag == cmd_reg.tag_in)
                begin
                    if (rdata_a.key > cmd_reg.key_in)
                    begin
                        rsp_next.status     = ST_OK;
                        rsp_next.out_key    = cmd_reg.key_in;
                        rsp_next.out_tag    = cmd_reg.tag_in;
                        rsp_next.out_parent = cmd_reg.parent_in;
                        cur_next.key     = cmd_reg.key_in;
                        cur_next.tag     = rdata_a.tag;
                        cur_next.item_id = rdata_a.item_id;
                        pos_next   = AW'(idx_reg);
                        state_next = S_UP_RD;
                    end
                    else
                    begin
                        state_next = S_DONE;
                    end
                end
                else
                begin
                    idx_next   = idx_reg + CW'(1);
                    state_next = S_SRCH;
                end
            end
            S_DONE:
            begin
                rsp_next.occupancy = 11'(count_reg);
                done_next  = 1'b1;
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pos_reg <= pos_next;
        idx_reg <= idx_next;
        cur_reg <= cur_next;
        cmd_reg <= cmd_next;
        rsp_reg <= rsp_next;
    end

    assign busy = (state_reg != S_IDLE);
    assign done = done_reg;
    assign rsp  = rsp_reg;
endmodule
`default_nettype wire

/* sv/min_heap_priority_queue_unit.sv */
// ----------------------------------------------------------------------------
// min_heap_priority_queue_unit
// binary min-heap of signed keys with tag, item id and decrease-key
//
//   channel  | ports               | transfer
//   ---------+---------------------+--------------------------
//   command  | start, busy, cmd    | start high, busy low
//   response | done, rsp           | done high for one cycle
//
// insert and decrease-key sift up: read the parent, then compare and move
// extract sifts down, reading both children over two ram read ports
// decrease-key scans the store by tag, reading each entry, before sifting
// reset empties the heap at once with no clearing pass
// responses cannot be stalled; the next transaction waits on busy
// ----------------------------------------------------------------------------
`default_nettype none
module min_heap_priority_queue_unit (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           start,
    input  wire mhpq_pkg::cmd_t cmd,
    output logic                busy,
    output logic                done,
    output mhpq_pkg::rsp_t      rsp
);
    import mhpq_pkg::*;

    mem_req_t mreq;
    entry_t   rdata_a;
    entry_t   rdata_b;

    mhpq_store u_store (
        .clk(clk), .req(mreq), .rdata_a(rdata_a), .rdata_b(rdata_b)
    );

    mhpq_ctrl u_ctrl (
        .clk(clk), .rst_n(rst_n), .start(start), .cmd(cmd),
        .busy(busy), .done(done), .rsp(rsp), .mreq(mreq),
        .rdata_a(rdata_a), .rdata_b(rdata_b)
    );

    a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("busy not raised after accepted transaction");

    a_done_one: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("response strobe longer than one cycle");

    a_occ_range: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (rsp.occupancy <= 11'(CAPACITY)))
        else $error("occupancy beyond capacity");

    a_full_ok: assert property (@(posedge clk) disable iff (!rst_n)
        (done && rsp.status == ST_FULL) |-> (rsp.occupancy == 11'(CAPACITY)))
        else $error("full reported below capacity");
endmodule
`default_nettype wire
